/* sv/hcbd_pkg.sv */
// ----------------------------------------------------------------------------
// hcbd_pkg
// Shared types, codes and helpers of the HTTP chunked body decoder.
// ----------------------------------------------------------------------------
package hcbd_pkg;

   // default sizes
   localparam int LINE_CHARS_DEF = 31;
   localparam int SIZE_BITS_DEF  = 31;

   // register reset values and indexes
   localparam logic [7:0] PACKET_SIZE_RESET = 8'd188;
   localparam logic       CSR_CHUNKED_MODE  = 1'b0;
   localparam logic       CSR_PACKET_SIZE   = 1'b1;

   // result status codes
   localparam logic [1:0] ST_PAYLOAD  = 2'd0;
   localparam logic [1:0] ST_BODY_END = 2'd1;
   localparam logic [1:0] ST_CLOSED   = 2'd2;

   // beat kinds
   localparam logic KIND_BYTE   = 1'b0;
   localparam logic KIND_CLOSED = 1'b1;

   // characters
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_X_LO  = 8'h78;
   localparam logic [7:0] CH_X_UP  = 8'h58;

   localparam logic [1:0] TRAILER_LEN = 2'd2;

   typedef enum logic [3:0] {
      PH_LINE  = 4'b0001,
      PH_DATA  = 4'b0010,
      PH_TRAIL = 4'b0100,
      PH_DONE  = 4'b1000
   } phase_type;

   typedef enum logic [5:0] {
      NP_WS     = 6'b000001,
      NP_SIGN   = 6'b000010,
      NP_ZERO   = 6'b000100,
      NP_PREFIX = 6'b001000,
      NP_DIGITS = 6'b010000,
      NP_STOP   = 6'b100000
   } num_phase_type;

   // size-line parser command
   typedef struct packed {
      logic take;    // parse one size-line char
      logic clear;   // line end, restart the parser
   } line_cmd_type;

   // {valid, digit} of one hex char
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39)      r = {1'b1, 4'(c - 8'h30)};
      else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
      else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
      return r;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
   endfunction

endpackage

/* sv/hcbd_line_parser.sv */
// ----------------------------------------------------------------------------
// hcbd_line_parser
// Chunk size line parser: strtol base 16 style, saturating, char limit.
// ----------------------------------------------------------------------------
module hcbd_line_parser #(
   parameter int LINE_CHARS = hcbd_pkg::LINE_CHARS_DEF,
   parameter int SIZE_BITS  = hcbd_pkg::SIZE_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  hcbd_pkg::line_cmd_type  cmd,
   input  logic [7:0]              char_in,
   output logic [SIZE_BITS-1:0]    value,
   output logic                    negative
);
   import hcbd_pkg::*;

   localparam int CW = $clog2(LINE_CHARS + 1);

   logic [SIZE_BITS-1:0] value_ff, value_in;
   logic [CW-1:0]        count_ff, count_in;
   num_phase_type        np_ff, np_in;
   logic                 neg_ff, neg_in;

   logic [4:0]           hv;
   logic [SIZE_BITS-1:0] added;
   logic                 is_zero;

   assign hv      = hex_digit(char_in);
   assign is_zero = (char_in == CH_ZERO);
   // saturate once the top nibble is in use
   assign added   = (|value_ff[SIZE_BITS-1 -: 4]) ? {SIZE_BITS{1'b1}}
                                                  : {value_ff[SIZE_BITS-5:0], hv[3:0]};

   always_comb begin
      value_in = value_ff;
      count_in = count_ff;
      np_in    = np_ff;
      neg_in   = neg_ff;
      if (cmd.clear) begin
         value_in = '0;
         count_in = '0;
         np_in    = NP_WS;
         neg_in   = 1'b0;
      end else if (cmd.take && (count_ff < CW'(LINE_CHARS))) begin
         count_in = count_ff + CW'(1);
         case (np_ff)
            NP_WS, NP_SIGN: begin
               if (np_ff == NP_WS && is_space(char_in)) begin
                  np_in = NP_WS;
               end else if (np_ff == NP_WS && (char_in == CH_PLUS || char_in == CH_MINUS)) begin
                  neg_in = (char_in == CH_MINUS);
                  np_in  = NP_SIGN;
               end else if (is_zero) begin
                  np_in = NP_ZERO;
               end else if (hv[4]) begin
                  value_in = added;
                  np_in    = NP_DIGITS;
               end else begin
                  np_in = NP_STOP;
               end
            end
            NP_ZERO: begin
               if (char_in == CH_X_LO || char_in == CH_X_UP) begin
                  np_in = NP_PREFIX;
               end else if (hv[4]) begin
                  value_in = added;
                  np_in    = NP_DIGITS;
               end else begin
                  np_in = NP_STOP;
               end
            end
            NP_PREFIX, NP_DIGITS: begin
               if (hv[4]) begin
                  value_in = added;
                  np_in    = NP_DIGITS;
               end else begin
                  np_in = NP_STOP;
               end
            end
            default: begin
               np_in = np_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
         count_ff <= '0;
         np_ff    <= NP_WS;
         neg_ff   <= 1'b0;
      end else begin
         value_ff <= value_in;
         count_ff <= count_in;
         np_ff    <= np_in;
         neg_ff   <= neg_in;
      end
   end

   assign value    = value_ff;
   assign negative = neg_ff;

endmodule

/* sv/hcbd_packer.sv */
// ----------------------------------------------------------------------------
// hcbd_packer
// Counts delivered bytes and flags the last byte of each packet.
// ----------------------------------------------------------------------------
module hcbd_packer (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] packet_size,
   output logic       packet_end
);
   logic [7:0] fill_ff, fill_in;
   logic [8:0] lim;
   logic [8:0] fill_next;

   // size 0 means 256
   assign lim        = {~|packet_size, packet_size};
   assign fill_next  = {1'b0, fill_ff} + 9'd1;
   assign packet_end = (fill_next >= lim);

   always_comb begin
      fill_in = fill_ff;
      if (step) begin
         fill_in = packet_end ? 8'd0 : fill_next[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= 8'd0;
      end else begin
         fill_ff <= fill_in;
      end
   end

endmodule

/* sv/http_chunked_body_decoder_top.sv */
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_top
// HTTP body decoder: plain or chunked transfer, delivered in marked packets.
// ----------------------------------------------------------------------------
// One beat is taken every cycle at full rate unless the output stalls.
// A beat is held in an input register, decoded by one pass of shallow
// logic (size line parser, chunk and trailer counters, packet counter)
// and lands in a result register, which lets the next beat in while a
// finished result waits for rsp_ready. Size-line beats except a zero-size
// line's end, trailer and post-body beats give no result and leave the
// output untouched. A close beat always answers status 2 without touching
// decoder state. Program chunked_mode and packet_size only while the block
// is idle; packet_size 0 means 256. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_top #(
   parameter int LINE_CHARS = hcbd_pkg::LINE_CHARS_DEF,
   parameter int SIZE_BITS  = hcbd_pkg::SIZE_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   // configuration
   input  logic       csr_wr_en,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata,
   // input beats
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_kind,
   input  logic [7:0] req_data,
   // result beats
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_packet_end,
   output logic [1:0] rsp_status
);
   import hcbd_pkg::*;

   // config registers
   logic       chunked_mode_ff;
   logic [7:0] packet_size_ff;

   // input register
   logic       in_vld_ff;
   logic       in_kind_ff;
   logic [7:0] in_data_ff;

   // decoder state
   phase_type            phase_ff, phase_in;
   logic [SIZE_BITS-1:0] rem_ff, rem_in, rem_dec;
   logic [1:0]           trail_ff, trail_in, trail_dec;

   // result register
   logic       rsp_vld_ff;
   logic [7:0] rsp_byte_ff;
   logic       rsp_end_ff;
   logic [1:0] rsp_status_ff;

   logic                 adv;
   logic                 has_result;
   logic [7:0]           res_byte;
   logic [1:0]           res_status;
   logic                 deliver;
   logic                 pk_end;
   line_cmd_type         line_cmd;
   logic [SIZE_BITS-1:0] line_value;
   logic                 line_neg;

   // beat moves from input register to result register
   assign adv       = in_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || adv;

   assign rem_dec   = rem_ff - {{(SIZE_BITS-1){1'b0}}, |rem_ff};
   assign trail_dec = trail_ff - {1'b0, |trail_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         chunked_mode_ff <= 1'b0;
         packet_size_ff  <= PACKET_SIZE_RESET;
      end else if (csr_wr_en) begin
         if (csr_index == CSR_CHUNKED_MODE) begin
            chunked_mode_ff <= csr_wdata[0];
         end else begin
            packet_size_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ready) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_kind_ff <= req_kind;
         in_data_ff <= req_data;
      end
   end

   hcbd_line_parser #(
      .LINE_CHARS (LINE_CHARS),
      .SIZE_BITS  (SIZE_BITS)
   ) u_line_parser (
      .clock    (clock),
      .reset    (reset),
      .cmd      (line_cmd),
      .char_in  (in_data_ff),
      .value    (line_value),
      .negative (line_neg)
   );

   hcbd_packer u_packer (
      .clock       (clock),
      .reset       (reset),
      .step        (deliver),
      .packet_size (packet_size_ff),
      .packet_end  (pk_end)
   );

   // decode one beat
   always_comb begin
      has_result = 1'b0;
      res_byte   = in_data_ff;
      res_status = ST_PAYLOAD;
      deliver    = 1'b0;
      line_cmd   = '0;
      phase_in   = phase_ff;
      rem_in     = rem_ff;
      trail_in   = trail_ff;
      if (adv) begin
         if (in_kind_ff == KIND_CLOSED) begin
            has_result = 1'b1;
            res_byte   = 8'd0;
            res_status = ST_CLOSED;
         end else if (!chunked_mode_ff) begin
            has_result = 1'b1;
            deliver    = 1'b1;
         end else begin
            case (phase_ff)
               PH_LINE: begin
                  if (in_data_ff == CH_LF) begin
                     line_cmd.clear = 1'b1;
                     if (line_value == '0) begin
                        // zero size (also "-0"): body is over
                        phase_in   = PH_DONE;
                        has_result = 1'b1;
                        res_byte   = 8'd0;
                        res_status = ST_BODY_END;
                     end else if (!line_neg) begin
                        rem_in   = line_value;
                        phase_in = PH_DATA;
                     end
                  end else begin
                     line_cmd.take = 1'b1;
                  end
               end
               PH_DATA: begin
                  rem_in = rem_dec;
                  if (rem_dec == '0) begin
                     trail_in = TRAILER_LEN;
                     phase_in = PH_TRAIL;
                  end
                  has_result = 1'b1;
                  deliver    = 1'b1;
               end
               PH_TRAIL: begin
                  trail_in = trail_dec;
                  if (trail_dec == 2'd0) begin
                     phase_in = PH_LINE;
                  end
               end
               PH_DONE: begin
                  phase_in = PH_DONE;   // drop the rest
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LINE;
         rem_ff   <= '0;
         trail_ff <= 2'd0;
      end else begin
         phase_ff <= phase_in;
         rem_ff   <= rem_in;
         trail_ff <= trail_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         rsp_vld_ff <= has_result;
      end else if (rsp_ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && has_result) begin
         rsp_byte_ff   <= res_byte;
         rsp_end_ff    <= deliver && pk_end;
         rsp_status_ff <= res_status;
      end
   end

   assign rsp_valid      = rsp_vld_ff;
   assign rsp_out_byte   = rsp_byte_ff;
   assign rsp_packet_end = rsp_end_ff;
   assign rsp_status     = rsp_status_ff;

`ifndef SYNTHESIS
   // data phase never sits on an empty chunk
   a_data_nonempty: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> (rem_ff != '0))
      else $error("data phase with zero bytes left");

   // trailer phase always has bytes left to skip
   a_trail_nonempty: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_TRAIL) |-> (trail_ff != 2'd0))
      else $error("trailer phase with nothing to skip");

   // non-payload results carry no byte and no packet mark
   a_status_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_status_ff != ST_PAYLOAD) |-> (!rsp_end_ff && rsp_byte_ff == 8'd0))
      else $error("status beat carries payload");

   // a held beat is not lost while the result register is blocked
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && !adv) |=> in_vld_ff)
      else $error("input beat dropped");
`endif

endmodule

/* bench/http_chunked_body_decoder_top_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_top_test
// Self-checking bench for the chunked body decoder. Byte and close beats go
// in through a valid/ready sender. An in-bench decoder tracks framing,
// size-line parsing and packet counting and queues the output beat that each
// accepted beat should cause. Every output beat is checked against that queue.
// Directed plain, framing and mode-switch cases, then random well-formed
// chunks with noise, end-of-body cases, then a plain stream with no idling.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_top_test;
   import hcbd_pkg::*;

   localparam int DRAIN_CYCLES = 8;     // lets beats that give no output drain
   localparam int STALL_LIMIT  = 5000;  // well above the longest legal quiet stretch
   localparam int LONG_HOLD    = 300;

   // characters not in the package
   localparam logic [7:0] CH_NINE = 8'h39;
   localparam logic [7:0] CH_A_LO = 8'h61;
   localparam logic [7:0] CH_F_LO = 8'h66;
   localparam logic [7:0] CH_A_UP = 8'h41;
   localparam logic [7:0] CH_F_UP = 8'h46;
   localparam logic [7:0] CH_VT   = 8'h0b;
   localparam logic [7:0] CH_FF   = 8'h0c;
   localparam logic [7:0] CH_SEMI = 8'h3b;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       packet_end;
      logic [1:0] status;
   } out_beat_type;

   logic       clock     = 1'b0;
   logic       reset     = 1'b1;
   logic       csr_wr_en = 1'b0;
   logic       csr_index = 1'b0;
   logic [7:0] csr_wdata = 8'd0;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_kind  = 1'b0;
   logic [7:0] req_data  = 8'd0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_packet_end;
   logic [1:0] rsp_status;

   http_chunked_body_decoder_top u_top (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_packet_end (rsp_packet_end),
      .rsp_status     (rsp_status)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Bench copy of the decoder state and configuration
   // ------------------------------------------------------------------------
   logic          mode_chunked = 1'b0;
   logic [7:0]    pkt_size     = PACKET_SIZE_RESET;
   phase_type     body_phase   = PH_LINE;
   logic [30:0]   chunk_left   = '0;
   logic [30:0]   size_acc     = '0;   // hex value of the size line so far
   int            size_chars   = 0;    // size-line chars taken, capped
   num_phase_type num_phase    = NP_WS;
   logic          size_neg     = 1'b0;
   logic [1:0]    trail_left   = '0;
   logic [7:0]    pkt_fill     = '0;

   out_beat_type  decoded_beats[$];    // output beats still owed by the block
   out_beat_type  oldest;
   int            mismatch_count = 0;
   int            beat_count     = 0;
   int            idle_cycles    = 0;

   // idling controls of the sender and the receiver
   logic          sender_gaps_on = 1'b1;
   logic          rsp_stalls_on  = 1'b1;
   int            rsp_hold_left  = 0;
   int            stall_left     = 0;

   function automatic logic hex_value(input logic [7:0] c, output logic [3:0] v);
      v = 4'd0;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         v = 4'(c - CH_ZERO);
         return 1'b1;
      end
      if (c >= CH_A_LO && c <= CH_F_LO) begin
         v = 4'(c - CH_A_LO + 8'd10);
         return 1'b1;
      end
      if (c >= CH_A_UP && c <= CH_F_UP) begin
         v = 4'(c - CH_A_UP + 8'd10);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // shift one hex digit in, saturating at the top of the size range
   function automatic void push_digit(input logic [3:0] d);
      if (size_acc > ({31{1'b1}} >> 4)) size_acc = {31{1'b1}};
      else size_acc = {size_acc[26:0], d};
   endfunction

   // strtol-style walk: whitespace, sign, 0 / 0x prefix, digits, stop
   function automatic void parse_size_char(input logic [7:0] c);
      logic       is_hex;
      logic [3:0] d;
      logic       blank;
      is_hex = hex_value(c, d);
      blank  = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
      case (num_phase)
         NP_WS, NP_SIGN: begin
            if (num_phase == NP_WS && blank) begin
               // leading whitespace skipped
            end else if (num_phase == NP_WS && (c == CH_PLUS || c == CH_MINUS)) begin
               size_neg  = (c == CH_MINUS);
               num_phase = NP_SIGN;
            end else if (c == CH_ZERO) begin
               num_phase = NP_ZERO;
            end else if (is_hex) begin
               push_digit(d);
               num_phase = NP_DIGITS;
            end else begin
               num_phase = NP_STOP;
            end
         end
         NP_ZERO: begin
            if (c == CH_X_LO || c == CH_X_UP) begin
               num_phase = NP_PREFIX;
            end else if (is_hex) begin
               push_digit(d);
               num_phase = NP_DIGITS;
            end else begin
               num_phase = NP_STOP;
            end
         end
         NP_PREFIX, NP_DIGITS: begin
            if (is_hex) begin
               push_digit(d);
               num_phase = NP_DIGITS;
            end else begin
               num_phase = NP_STOP;
            end
         end
         default: ;
      endcase
   endfunction

   // count a delivered byte into the current packet; size 0 means 256
   function automatic out_beat_type pack_byte(input logic [7:0] b);
      out_beat_type r;
      int           nxt;
      int           lim;
      nxt          = pkt_fill + 1;
      lim          = (pkt_size == 8'd0) ? 256 : pkt_size;
      r.out_byte   = b;
      r.packet_end = (nxt >= lim);
      r.status     = ST_PAYLOAD;
      pkt_fill     = r.packet_end ? 8'd0 : 8'(nxt);
      return r;
   endfunction

   // advance the bench decoder by one accepted beat; 1 when it yields output
   function automatic logic decode_beat(input logic kind, input logic [7:0] c,
                                        output out_beat_type r);
      logic        produced;
      logic [30:0] v;
      logic        neg;
      r        = '0;
      produced = 1'b0;
      if (kind == KIND_CLOSED) begin
         r.status = ST_CLOSED;
         produced = 1'b1;
      end else if (!mode_chunked) begin
         r        = pack_byte(c);
         produced = 1'b1;
      end else begin
         case (body_phase)
            PH_LINE: begin
               if (c == CH_LF) begin
                  v          = size_acc;
                  neg        = size_neg;
                  size_acc   = '0;
                  size_chars = 0;
                  num_phase  = NP_WS;
                  size_neg   = 1'b0;
                  if (v == '0) begin
                     body_phase = PH_DONE;
                     r.status   = ST_BODY_END;
                     produced   = 1'b1;
                  end else if (!neg) begin
                     chunk_left = v;
                     body_phase = PH_DATA;
                  end
               end else if (size_chars < LINE_CHARS_DEF) begin
                  size_chars++;
                  parse_size_char(c);
               end
            end
            PH_DATA: begin
               if (chunk_left != '0) chunk_left = chunk_left - 1'b1;
               if (chunk_left == '0) begin
                  trail_left = TRAILER_LEN;
                  body_phase = PH_TRAIL;
               end
               r        = pack_byte(c);
               produced = 1'b1;
            end
            PH_TRAIL: begin
               if (trail_left != '0) trail_left = trail_left - 1'b1;
               if (trail_left == '0) body_phase = PH_LINE;
            end
            default: ;   // body over, bytes dropped
         endcase
      end
      return produced;
   endfunction

   // ------------------------------------------------------------------------
   // Sender side
   // ------------------------------------------------------------------------
   // Offers one beat, holding it until accepted, then decodes it.
   task automatic send_beat(input logic kind, input logic [7:0] data);
      out_beat_type r;
      if (sender_gaps_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind  <= kind;
      req_data  <= data;
      do @(posedge clock); while (!req_ready);
      if (decode_beat(kind, data, r)) decoded_beats.push_back(r);
      beat_count++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_beat(KIND_BYTE, s[i]);
   endtask

   // Sender goes quiet until every owed beat is out, then lets the pipe empty
   // of beats that give no output.
   task automatic settle();
      req_valid <= 1'b0;
      while (decoded_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [7:0] value);
      settle();
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      if (idx == CSR_CHUNKED_MODE) mode_chunked = value[0];
      else pkt_size = value;
   endtask

   function automatic logic [7:0] ws_char();
      case ($urandom_range(0, 4))
         0:       return CH_TAB;
         1:       return CH_VT;
         2:       return CH_FF;
         3:       return CH_CR;
         default: return CH_SPACE;
      endcase
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
      if (nib < 4'd10) return CH_ZERO + 8'(nib);
      return (upper ? CH_A_UP : CH_A_LO) + 8'(nib) - 8'd10;
   endfunction

   // Size line with random formatting. val must be nonzero. Some lines are
   // padded so the 31-char cap can cut off trailing digits; some carry a long
   // extension tail of arbitrary bytes.
   task automatic send_size_line(input logic [47:0] val, input logic neg);
      logic [7:0] text[$];
      logic [7:0] b;
      int         ndig;
      int         pad;
      ndig = 1;
      for (int i = 1; i < 12; i++) if (val[4*i +: 4] != 4'd0) ndig = i + 1;
      if (!neg && ndig < 8 && $urandom_range(0, 5) == 0) begin
         pad = 31 - ndig + $urandom_range(0, ndig - 1);
         repeat (pad) text.push_back(ws_char());
      end else begin
         repeat ($urandom_range(0, 2)) text.push_back(ws_char());
         if (neg) text.push_back(CH_MINUS);
         else if ($urandom_range(0, 3) == 0) text.push_back(CH_PLUS);
         case ($urandom_range(0, 3))
            1: begin
               text.push_back(CH_ZERO);
               text.push_back($urandom_range(0, 1) ? CH_X_UP : CH_X_LO);
            end
            2:       repeat ($urandom_range(1, 3)) text.push_back(CH_ZERO);
            default: ;
         endcase
      end
      for (int i = ndig - 1; i >= 0; i--)
         text.push_back(hex_char(val[4*i +: 4], 1'($urandom_range(0, 1))));
      if ($urandom_range(0, 3) == 0) begin
         text.push_back(CH_SEMI);
         repeat ($urandom_range(0, 40)) begin
            do b = 8'($urandom_range(0, 255)); while (b == CH_LF);
            text.push_back(b);
         end
      end
      if ($urandom_range(0, 1)) text.push_back(CH_CR);
      text.push_back(CH_LF);
      foreach (text[i]) send_beat(KIND_BYTE, text[i]);
   endtask

   // Runs out the data of the open chunk, then its trailer; close beats mixed in.
   task automatic finish_chunk();
      while (body_phase == PH_DATA) begin
         if ($urandom_range(0, 19) == 0) send_beat(KIND_CLOSED, 8'($urandom));
         else send_beat(KIND_BYTE, 8'($urandom));
      end
      while (body_phase == PH_TRAIL) begin
         if ($urandom_range(0, 4) == 0) send_beat(KIND_BYTE, 8'($urandom));
         else send_beat(KIND_BYTE, (trail_left == 2'd2) ? CH_CR : CH_LF);
      end
   endtask

   // ------------------------------------------------------------------------
   // Receiver side: random stall bursts, plus one long hold on request
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_hold_left = rsp_hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (rsp_stalls_on && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 16) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Output check: each beat against the oldest owed beat, field by field.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (decoded_beats.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected output beat: byte %02h end %b status %0d",
                        rsp_out_byte, rsp_packet_end, rsp_status);
         end else begin
            oldest = decoded_beats.pop_front();
            if (rsp_out_byte !== oldest.out_byte || rsp_packet_end !== oldest.packet_end ||
                rsp_status !== oldest.status) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("output mismatch: byte %02h/%02h end %b/%b status %0d/%0d %s",
                           oldest.out_byte, rsp_out_byte, oldest.packet_end,
                           rsp_packet_end, oldest.status, rsp_status,
                           "(expected/actual)");
            end
         end
      end
   end

   // Watchdog: too long with no beat moving on either side.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
         $display("http_chunked_body_decoder_top_test NOT OK");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   // Plain pass-through, first under reset settings, then with 3-byte packets.
   // Fill is 2 when the size drops to 3, so the next byte closes a packet.
   task automatic test_plain_bytes();
      send_beat(KIND_BYTE, 8'h00);
      send_beat(KIND_BYTE, 8'hff);
      write_csr(CSR_CHUNKED_MODE, 8'd0);
      write_csr(CSR_PACKET_SIZE, 8'd3);
      send_beat(KIND_BYTE, 8'h80);
      send_beat(KIND_CLOSED, 8'hff);
      send_beat(KIND_BYTE, 8'h7f);
      send_beat(KIND_BYTE, CH_LF);
   endtask

   // One ordinary chunk, an ignored negative size, then whitespace, sign and
   // upper-case prefix on a one-byte chunk.
   task automatic test_chunk_framing();
      write_csr(CSR_CHUNKED_MODE, 8'd1);
      write_csr(CSR_PACKET_SIZE, 8'd4);
      send_text("3\r\nA\nZ\r\n");
      send_text(" -2\r\n");
      send_beat(KIND_CLOSED, 8'h00);
      send_text("\t+0X1\r\nq\r\n");
   endtask

   // Parser and chunk counters must survive a trip through plain mode, both
   // mid size line and mid data.
   task automatic test_mode_switch();
      send_text("2");
      write_csr(CSR_CHUNKED_MODE, 8'd0);
      send_text("9f\n");
      write_csr(CSR_CHUNKED_MODE, 8'd1);
      send_text("0\r\n");                     // completes size 0x20
      repeat (10) send_beat(KIND_BYTE, 8'($urandom));
      write_csr(CSR_CHUNKED_MODE, 8'd0);
      repeat (4) send_beat(KIND_BYTE, 8'($urandom));
      write_csr(CSR_CHUNKED_MODE, 8'd1);
      finish_chunk();
   endtask

   // Random well-formed chunks, with ignored negative sizes (often saturating),
   // close beats and packet size changes mixed in. Opens with a long receiver
   // hold so the block backs up onto its input.
   task automatic test_random_chunks();
      logic [47:0] big;
      int          stop_at;
      int          size_changes;
      stop_at      = beat_count + 700;
      size_changes = 0;
      rsp_hold_left = LONG_HOLD;
      send_size_line(48'h40, 1'b0);
      finish_chunk();
      while (beat_count < stop_at) begin
         if ($urandom_range(0, 5) == 0) begin
            sender_gaps_on = ($urandom_range(0, 2) != 0);
            rsp_stalls_on  = ($urandom_range(0, 2) != 0);
         end
         case ($urandom_range(0, 24))
            0: begin
               case (size_changes)
                  0:       write_csr(CSR_PACKET_SIZE, 8'd1);
                  1:       write_csr(CSR_PACKET_SIZE, 8'd255);
                  2:       write_csr(CSR_PACKET_SIZE, 8'd2);
                  default: write_csr(CSR_PACKET_SIZE, 8'($urandom_range(1, 255)));
               endcase
               size_changes++;
            end
            1, 2: begin
               big = {16'($urandom), 32'($urandom)} >> $urandom_range(0, 44);
               if (big == '0) big = 48'd1;
               send_size_line(big, 1'b1);
            end
            3:       send_beat(KIND_CLOSED, 8'($urandom));
            default: begin
               if ($urandom_range(0, 9) == 0) send_size_line(48'($urandom_range(25, 400)), 1'b0);
               else send_size_line(48'($urandom_range(1, 24)), 1'b0);
               finish_chunk();
            end
         endcase
      end
   endtask

   // Zero-size line ends the body; which spelling of zero is picked at random.
   // Bytes after it are dropped, close beats still answer.
   task automatic test_body_end();
      case ($urandom_range(0, 7))
         0: send_text("0\r\n");
         1: send_text("\n");                  // empty line
         2: send_text("-0\n");                // negative zero still ends
         3: send_text("0x\r\n");              // prefix with no digit
         4: send_text(" \t+0X\n");
         5: send_text("zz;\r\n");             // unparsable
         6: send_text("000\n");
         default: begin
            repeat (33) send_beat(KIND_BYTE, CH_SPACE);
            send_text("7\r\n");               // digit beyond the char cap
         end
      endcase
      for (int i = 0; i < 24; i++) begin
         if (i % 6 == 5) send_beat(KIND_CLOSED, 8'($urandom));
         else send_beat(KIND_BYTE, 8'($urandom));
      end
   endtask

   // Closing stretch with no idling: plain mode after the body ended, 256-byte
   // packets, then a size shrunk below the current fill, then 1-byte packets.
   task automatic test_plain_stream();
      sender_gaps_on = 1'b0;
      rsp_stalls_on  = 1'b0;
      write_csr(CSR_CHUNKED_MODE, 8'd0);
      write_csr(CSR_PACKET_SIZE, 8'd0);
      repeat (300) send_beat(KIND_BYTE, 8'($urandom));
      write_csr(CSR_PACKET_SIZE, 8'd5);
      repeat (20) send_beat(KIND_BYTE, 8'($urandom));
      write_csr(CSR_PACKET_SIZE, 8'd1);
      repeat (20) send_beat(KIND_BYTE, 8'($urandom));
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_plain_bytes();
      test_chunk_framing();
      test_mode_switch();
      test_random_chunks();
      test_body_end();
      test_plain_stream();
      settle();
      if (mismatch_count == 0) $display("http_chunked_body_decoder_top_test OK");
      else $display("http_chunked_body_decoder_top_test NOT OK");
      $finish;
   end

endmodule
